/* rtl/pwc_pkg.sv */
package pwc_pkg;

	// Width of the saturating tick counter.
	localparam int COUNT_WIDTH = 16;
	// Width that both the counter and the 16-bit limits fit in for comparison.
	localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam logic [2:0] MODE_IDLE      = 3'd0;
	localparam logic [2:0] MODE_JUDGE     = 3'd1;
	localparam logic [2:0] MODE_MAN_UP    = 3'd2;
	localparam logic [2:0] MODE_MAN_DOWN  = 3'd3;
	localparam logic [2:0] MODE_AUTO_UP   = 3'd4;
	localparam logic [2:0] MODE_AUTO_DOWN = 3'd5;
	localparam logic [2:0] MODE_JAM_REV   = 3'd6;

	localparam logic [2:0] CFG_HOLD      = 3'd0;
	localparam logic [2:0] CFG_REVERSE   = 3'd1;
	localparam logic [2:0] CFG_UP_STEP   = 3'd2;
	localparam logic [2:0] CFG_DOWN_STEP = 3'd3;
	localparam logic [2:0] CFG_PERIOD    = 3'd4;

	localparam logic [15:0] HOLD_RESET      = 16'd5;
	localparam logic [15:0] REVERSE_RESET   = 16'd5;
	localparam logic [15:0] UP_STEP_RESET   = 16'd10;
	localparam logic [15:0] DOWN_STEP_RESET = 16'd100;
	localparam logic [15:0] PERIOD_RESET    = 16'd5000;
	localparam logic [15:0] DUTY_RESET      = 16'd3750;

	typedef struct packed {
		logic driver_up;
		logic driver_down;
		logic pass_up;
		logic pass_down;
		logic lock_off;
		logic top_limit;
		logic bottom_limit;
		logic jam;
	} tick_t;

	typedef struct packed {
		logic [15:0] hold_ticks;
		logic [15:0] reverse_ticks;
		logic [15:0] up_step;
		logic [15:0] down_step;
		logic [15:0] pwm_period;
	} cfg_t;

	typedef struct packed {
		logic [2:0]             mode;
		logic [COUNT_WIDTH-1:0] tick_count;
		logic [15:0]            duty;
		logic [1:0]             press_source;
		logic                   after_manual;
	} state_t;

	typedef struct packed {
		logic        motor_up;
		logic        motor_down;
		logic [15:0] duty_compare;
		logic [2:0]  mode;
	} result_t;

endpackage

/* rtl/pwc_step.sv */
module pwc_step
	import pwc_pkg::*;
(
	input  tick_t   tick,
	input  cfg_t    cfg,
	input  state_t  cur,
	output state_t  nxt,
	output result_t res
);

	logic [3:0]             btn;
	logic                   held;
	logic                   down_src;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic                   reach_hold;
	logic                   reach_rev;
	logic [15:0]            duty_up;
	logic [15:0]            duty_dn;
	logic                   mu;
	logic                   md;

	assign btn = {tick.pass_down, tick.pass_up, tick.driver_down, tick.driver_up};
	assign held = btn[cur.press_source];
	assign down_src = cur.press_source[0];
	assign cnt_inc = (cur.tick_count == CNT_MAX) ? cur.tick_count : cur.tick_count + 1'b1;
	assign reach_hold = (CMP_W'(cnt_inc) >= CMP_W'(cfg.hold_ticks)) || (cnt_inc == CNT_MAX);
	assign reach_rev = (CMP_W'(cnt_inc) >= CMP_W'(cfg.reverse_ticks)) || (cnt_inc == CNT_MAX);

	// The duty value wraps to the period once a step would take it to zero or below.
	assign duty_up = (cur.duty <= cfg.up_step) ? cfg.pwm_period : cur.duty - cfg.up_step;
	assign duty_dn = (cur.duty <= cfg.down_step) ? cfg.pwm_period : cur.duty - cfg.down_step;

	always_comb begin
		nxt = cur;
		mu = 1'b0;
		md = 1'b0;
		case (cur.mode)
			MODE_JUDGE: begin
				nxt.tick_count = cnt_inc;
				if (reach_hold) begin
					if (held) begin
						nxt.after_manual = 1'b1;
						nxt.mode = down_src ? MODE_MAN_DOWN : MODE_MAN_UP;
					end else if (!cur.after_manual) begin
						nxt.mode = down_src ? MODE_AUTO_DOWN : MODE_AUTO_UP;
					end else begin
						// A short press straight after a manual run is dropped.
						nxt.after_manual = 1'b0;
						nxt.mode = MODE_IDLE;
					end
				end
			end
			MODE_MAN_UP, MODE_AUTO_UP: begin
				if (tick.jam) begin
					nxt.tick_count = '0;
					nxt.mode = MODE_JAM_REV;
				end else if ((cur.mode == MODE_MAN_UP) ? !held : tick.top_limit) begin
					nxt.mode = MODE_IDLE;
				end else begin
					mu = 1'b1;
					nxt.duty = duty_up;
				end
			end
			MODE_MAN_DOWN, MODE_AUTO_DOWN: begin
				if ((cur.mode == MODE_MAN_DOWN) ? !held : tick.bottom_limit) begin
					nxt.mode = MODE_IDLE;
				end else begin
					md = 1'b1;
					nxt.duty = duty_dn;
				end
			end
			MODE_JAM_REV: begin
				md = 1'b1;
				nxt.duty = duty_dn;
				nxt.tick_count = cnt_inc;
				if (reach_rev) begin
					nxt.mode = MODE_IDLE;
				end
			end
			default: begin
				// Idle, and the unused code, which behaves as idle.
				nxt.mode = MODE_IDLE;
				if (tick.driver_up) begin
					nxt.press_source = 2'd0;
					nxt.tick_count = '0;
					nxt.mode = MODE_JUDGE;
				end else if (tick.driver_down) begin
					nxt.press_source = 2'd1;
					nxt.tick_count = '0;
					nxt.mode = MODE_JUDGE;
				end else if (tick.lock_off && tick.pass_up) begin
					nxt.press_source = 2'd2;
					nxt.tick_count = '0;
					nxt.mode = MODE_JUDGE;
				end else if (tick.lock_off && tick.pass_down) begin
					nxt.press_source = 2'd3;
					nxt.tick_count = '0;
					nxt.mode = MODE_JUDGE;
				end
			end
		endcase
	end

	assign res.motor_up = mu;
	assign res.motor_down = md;
	assign res.duty_compare = nxt.duty;
	assign res.mode = nxt.mode;

endmodule

/* rtl/power_window_controller_unit.sv */
// Channel   Direction  Handshake              Payload
// in        to block   in_valid / in_ready    driver_up .. jam, one bit each
// out       from block out_valid / out_ready  motor_up, motor_down, duty_compare, mode
// cfg       to block   cfg_we                 cfg_index (3 bits), cfg_data (16 bits)
//
// Each item passes an input register and then the result register, which offers it;
// one item a cycle is sustained while out_ready stays high, with the single mode
// update sitting between the two registers.
// Reset clears the mode machine, the counter, the after-manual flag, duty to 3750
// and every configuration register to its default.
// A stalled output holds its item; the input register still takes one more item,
// and only then does in_ready fall.
module power_window_controller_unit
	import pwc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        driver_up,
	input  logic        driver_down,
	input  logic        pass_up,
	input  logic        pass_down,
	input  logic        lock_off,
	input  logic        top_limit,
	input  logic        bottom_limit,
	input  logic        jam,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        motor_up,
	output logic        motor_down,
	output logic [15:0] duty_compare,
	output logic [2:0]  mode,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers, to be written only while the block is idle; the block itself does not enforce this.
	cfg_t cfg_q;

	// Mode machine state, advanced once per item as it leaves the input register.
	state_t state_q;
	state_t state_nxt;

	// Input register stage.
	logic  valid_s1;
	tick_t tick_s1;

	// Result register.
	logic    out_valid_q;
	result_t res_q;
	result_t res_nxt;

	logic advance;

	// The item in the input register moves on whenever the result register is free
	// or is being emptied in this cycle.
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks <= HOLD_RESET;
			cfg_q.reverse_ticks <= REVERSE_RESET;
			cfg_q.up_step <= UP_STEP_RESET;
			cfg_q.down_step <= DOWN_STEP_RESET;
			cfg_q.pwm_period <= PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HOLD:      cfg_q.hold_ticks <= cfg_data;
				CFG_REVERSE:   cfg_q.reverse_ticks <= cfg_data;
				CFG_UP_STEP:   cfg_q.up_step <= cfg_data;
				CFG_DOWN_STEP: cfg_q.down_step <= cfg_data;
				CFG_PERIOD:    cfg_q.pwm_period <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1 <= '{driver_up, driver_down, pass_up, pass_down,
				lock_off, top_limit, bottom_limit, jam};
		end
	end

	pwc_step u_step (
		.tick (tick_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= MODE_IDLE;
			state_q.tick_count <= '0;
			state_q.duty <= DUTY_RESET;
			state_q.press_source <= 2'd0;
			state_q.after_manual <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign motor_up = res_q.motor_up;
	assign motor_down = res_q.motor_down;
	assign duty_compare = res_q.duty_compare;
	assign mode = res_q.mode;

endmodule

/* rtl/pwc_checker.sv */
module pwc_checker
	import pwc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        motor_up,
	input logic        motor_down,
	input logic [15:0] duty_compare,
	input logic [2:0]  mode
);

	// The motor is never driven both ways at once.
	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(motor_up && motor_down))
		else $error("motor driven up and down together");

	// Upward drive only ever comes with an up mode that carries on.
	a_up_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && motor_up) |-> (mode == MODE_MAN_UP || mode == MODE_AUTO_UP))
		else $error("motor up outside an up mode");

	// Downward drive comes with a down mode, or with the last reversal tick.
	a_down_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && motor_down) |-> (mode == MODE_MAN_DOWN || mode == MODE_AUTO_DOWN
			|| mode == MODE_JAM_REV || mode == MODE_IDLE))
		else $error("motor down outside a down mode");

	// A stalled result holds its value.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(duty_compare) && $stable(mode)))
		else $error("stalled result changed");

endmodule

bind power_window_controller_unit pwc_checker u_pwc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.motor_up     (motor_up),
	.motor_down   (motor_down),
	.duty_compare (duty_compare),
	.mode         (mode)
);

/* dv/power_window_controller_unit_tb.sv */
`timescale 1ns / 1ps
module power_window_controller_unit_tb;
	import pwc_pkg::*;

	// Run length and pacing.
	localparam int RANDOM_ITEMS   = 1400;
	localparam int PHASE_ITEMS    = 280;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 4;
	localparam int CYCLE_LIMIT    = 2000000;

	// Latched press source, in the block's own coding: odd codes move the window down.
	localparam logic [1:0] SRC_DRIVER_UP   = 2'd0;
	localparam logic [1:0] SRC_DRIVER_DOWN = 2'd1;
	localparam logic [1:0] SRC_PASS_UP     = 2'd2;
	localparam logic [1:0] SRC_PASS_DOWN   = 2'd3;

	// Tick items used by the directed tests. Bit order follows tick_t:
	// driver_up, driver_down, pass_up, pass_down, lock_off, top_limit, bottom_limit, jam.
	localparam tick_t NO_PRESS     = 8'b0000_0000;
	localparam tick_t DRV_UP       = 8'b1000_0000;
	localparam tick_t DRV_DOWN     = 8'b0100_0000;
	localparam tick_t PASS_UP_OK   = 8'b0010_1000;
	localparam tick_t PASS_DOWN_OK = 8'b0001_1000;
	localparam tick_t ALL_PRESSED  = 8'b1111_1000;
	localparam tick_t TOP_HIT      = 8'b0000_0100;
	localparam tick_t BOTTOM_HIT   = 8'b0000_0010;
	localparam tick_t JAM_HIT      = 8'b0000_0001;

	// Ways in which the result side accepts items.
	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_EVERY_THIRD,
		READY_SPARSE
	} ready_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	tick_t       tick_drv = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        motor_up;
	logic        motor_down;
	logic [15:0] duty_compare;
	logic [2:0]  mode;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = CFG_HOLD;
	logic [15:0] cfg_data = '0;

	// Our own copy of the controller: its registers and its state.
	cfg_t                   win_cfg;
	logic [2:0]             win_mode;
	logic [COUNT_WIDTH-1:0] win_count;
	logic [15:0]            win_duty;
	logic [1:0]             win_src;
	logic                   win_after_manual;

	// Window results still owed by the block, oldest first.
	result_t expected_results[$];
	result_t oldest_result;

	int error_count = 0;
	int cycle_count = 0;
	int random_items = 0;
	int burst_left = 0;

	// The test asks for a long hold-off by bumping the request count; the receiver
	// process notices the difference and counts the stall out itself.
	int           holdoff_requests = 0;
	int           holdoff_served = 0;
	int           holdoff_left = 0;
	ready_style_t ready_style = READY_ALWAYS;
	int           style_left = 0;

	power_window_controller_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.driver_up    (tick_drv.driver_up),
		.driver_down  (tick_drv.driver_down),
		.pass_up      (tick_drv.pass_up),
		.pass_down    (tick_drv.pass_down),
		.lock_off     (tick_drv.lock_off),
		.top_limit    (tick_drv.top_limit),
		.bottom_limit (tick_drv.bottom_limit),
		.jam          (tick_drv.jam),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.motor_up     (motor_up),
		.motor_down   (motor_down),
		.duty_compare (duty_compare),
		.mode         (mode),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// The run is bounded: a hung handshake ends it as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Window controller model
	// ------------------------------------------------------------------

	function automatic void reset_window_model();
		win_cfg.hold_ticks    = HOLD_RESET;
		win_cfg.reverse_ticks = REVERSE_RESET;
		win_cfg.up_step       = UP_STEP_RESET;
		win_cfg.down_step     = DOWN_STEP_RESET;
		win_cfg.pwm_period    = PERIOD_RESET;
		win_mode         = MODE_IDLE;
		win_count        = '0;
		win_duty         = DUTY_RESET;
		win_src          = SRC_DRIVER_UP;
		win_after_manual = 1'b0;
	endfunction

	// The counter saturates, and sitting at its ceiling counts as having arrived.
	function automatic bit count_reached(logic [15:0] limit);
		return (win_count >= limit) || (win_count == CNT_MAX);
	endfunction

	function automatic void count_tick();
		if (win_count != CNT_MAX)
			win_count = win_count + 1'b1;
	endfunction

	// Each moving tick lowers the compare value; at zero or below it wraps to the period.
	function automatic void step_duty(logic [15:0] step);
		if (win_duty <= step)
			win_duty = win_cfg.pwm_period;
		else
			win_duty = win_duty - step;
	endfunction

	function automatic result_t predict_window_tick(tick_t t);
		logic [3:0] buttons;
		logic [1:0] pick;
		logic       found;
		logic       going_down;
		result_t    r;
		buttons    = {t.pass_down, t.pass_up, t.driver_down, t.driver_up};
		pick       = SRC_DRIVER_UP;
		found      = 1'b0;
		going_down = (win_src == SRC_DRIVER_DOWN) || (win_src == SRC_PASS_DOWN);
		r          = '0;
		case (win_mode)
			MODE_JUDGE: begin
				count_tick();
				// The deciding tick never moves the motor.
				if (count_reached(win_cfg.hold_ticks)) begin
					if (buttons[win_src]) begin
						win_after_manual = 1'b1;
						win_mode = going_down ? MODE_MAN_DOWN : MODE_MAN_UP;
					end else if (!win_after_manual) begin
						win_mode = going_down ? MODE_AUTO_DOWN : MODE_AUTO_UP;
					end else begin
						// A short press straight after a manual run is swallowed.
						win_after_manual = 1'b0;
						win_mode = MODE_IDLE;
					end
				end
			end
			MODE_MAN_UP, MODE_AUTO_UP: begin
				// A jam outranks both release and the limit switch.
				if (t.jam) begin
					win_count = '0;
					win_mode = MODE_JAM_REV;
				end else if (win_mode == MODE_MAN_UP ? !buttons[win_src] : t.top_limit) begin
					win_mode = MODE_IDLE;
				end else begin
					r.motor_up = 1'b1;
					step_duty(win_cfg.up_step);
				end
			end
			MODE_MAN_DOWN, MODE_AUTO_DOWN: begin
				if (win_mode == MODE_MAN_DOWN ? !buttons[win_src] : t.bottom_limit) begin
					win_mode = MODE_IDLE;
				end else begin
					r.motor_down = 1'b1;
					step_duty(win_cfg.down_step);
				end
			end
			MODE_JAM_REV: begin
				r.motor_down = 1'b1;
				step_duty(win_cfg.down_step);
				count_tick();
				if (count_reached(win_cfg.reverse_ticks))
					win_mode = MODE_IDLE;
			end
			default: begin
				// Idle: latch the highest-priority button allowed to start a press.
				if (t.driver_up) begin
					found = 1'b1;
					pick = SRC_DRIVER_UP;
				end else if (t.driver_down) begin
					found = 1'b1;
					pick = SRC_DRIVER_DOWN;
				end else if (t.lock_off && t.pass_up) begin
					found = 1'b1;
					pick = SRC_PASS_UP;
				end else if (t.lock_off && t.pass_down) begin
					found = 1'b1;
					pick = SRC_PASS_DOWN;
				end
				win_mode = MODE_IDLE;
				if (found) begin
					win_src = pick;
					win_count = '0;
					win_mode = MODE_JUDGE;
				end
			end
		endcase
		r.duty_compare = win_duty;
		r.mode = win_mode;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Item traffic
	// ------------------------------------------------------------------

	// Offers one tick item and holds it until the block takes it. The expected
	// result is worked out at the edge of acceptance.
	task automatic send_tick(input tick_t t);
		in_valid <= 1'b1;
		tick_drv <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.push_back(predict_window_tick(t));
	endtask

	// Sender pacing: bursts of random length, with a random gap (sometimes none)
	// in front of each burst.
	task automatic offer_tick(input tick_t t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send_tick(t);
	endtask

	task automatic repeat_tick(input tick_t t, input int count);
		repeat (count) offer_tick(t);
	endtask

	// Stops offering and waits until every owed result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] index, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Registers are only ever written with the block idle, so the drain comes first.
	task automatic write_config(input cfg_t c);
		drain_results();
		put_reg(CFG_HOLD, c.hold_ticks);
		put_reg(CFG_REVERSE, c.reverse_ticks);
		put_reg(CFG_UP_STEP, c.up_step);
		put_reg(CFG_DOWN_STEP, c.down_step);
		put_reg(CFG_PERIOD, c.pwm_period);
		cfg_we <= 1'b0;
		win_cfg = c;
		@(posedge clk);
	endtask

	function automatic cfg_t make_config(input logic [15:0] hold, input logic [15:0] reverse,
			input logic [15:0] up, input logic [15:0] down, input logic [15:0] period);
		cfg_t c;
		c.hold_ticks    = hold;
		c.reverse_ticks = reverse;
		c.up_step       = up;
		c.down_step     = down;
		c.pwm_period    = period;
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// The receiver keeps its own ready pattern, switching style every so often,
	// and honours a long hold-off whenever the test asks for one.
	always @(posedge clk) begin
		if (holdoff_served != holdoff_requests) begin
			holdoff_served <= holdoff_requests;
			holdoff_left <= HOLDOFF_CYCLES;
			out_ready <= 1'b0;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				ready_style <= ready_style_t'($urandom_range(0, 3));
				style_left <= $urandom_range(20, 200);
			end else begin
				style_left <= style_left - 1;
			end
			case (ready_style)
				READY_ALWAYS:      out_ready <= 1'b1;
				READY_COIN:        out_ready <= 1'($urandom_range(0, 1));
				READY_EVERY_THIRD: out_ready <= (style_left % 3 == 0);
				default:           out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Every accepted result is held against the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result item: mode %0d, duty_compare %0d", mode, duty_compare);
				error_count++;
			end else begin
				oldest_result = expected_results.pop_front();
				if (motor_up !== oldest_result.motor_up) begin
					$error("motor_up: expected %0d, got %0d", oldest_result.motor_up, motor_up);
					error_count++;
				end
				if (motor_down !== oldest_result.motor_down) begin
					$error("motor_down: expected %0d, got %0d",
						oldest_result.motor_down, motor_down);
					error_count++;
				end
				if (duty_compare !== oldest_result.duty_compare) begin
					$error("duty_compare: expected %0d, got %0d",
						oldest_result.duty_compare, duty_compare);
					error_count++;
				end
				if (mode !== oldest_result.mode) begin
					$error("mode: expected %0d, got %0d", oldest_result.mode, mode);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: a short press becomes an automatic run up to the top limit,
	// then a held press becomes a manual run down, all with the default registers.
	task automatic test_reset_defaults();
		offer_tick(DRV_UP);
		repeat_tick(NO_PRESS, 8);
		offer_tick(TOP_HIT);
		repeat_tick(DRV_DOWN, 8);
		offer_tick(NO_PRESS);
	endtask

	// Driver buttons outrank passenger ones; passenger buttons need the lock off.
	task automatic test_button_priority();
		write_config(make_config(16'd1, 16'd1, 16'd10, 16'd100, 16'd5000));
		repeat_tick(ALL_PRESSED, 3);
		offer_tick(NO_PRESS);
		repeat_tick(ALL_PRESSED & ~DRV_UP, 3);
		offer_tick(NO_PRESS);
		repeat_tick(PASS_UP_OK | PASS_DOWN_OK, 3);
		offer_tick(NO_PRESS);
		repeat_tick(PASS_DOWN_OK, 3);
		offer_tick(NO_PRESS);
		// With the child lock on, passenger buttons must be ignored entirely.
		repeat_tick(8'b0011_0000, 2);
	endtask

	// Once a passenger press has been latched, dropping the lock does not stop it.
	task automatic test_lock_during_press();
		offer_tick(PASS_UP_OK);
		repeat_tick(8'b0010_0000, 3);
		offer_tick(NO_PRESS);
	endtask

	// A short press right after a manual run is swallowed; the next one is honoured.
	task automatic test_short_press_after_manual();
		repeat_tick(DRV_UP, 3);
		offer_tick(NO_PRESS);
		offer_tick(DRV_UP);
		repeat_tick(NO_PRESS, 2);
		offer_tick(DRV_UP);
		repeat_tick(NO_PRESS, 3);
		offer_tick(TOP_HIT);
	endtask

	// Limits are ignored in manual modes; a jam only matters while moving up and
	// outranks release and the limit on the same tick.
	task automatic test_limits_and_jam();
		repeat_tick(DRV_UP | TOP_HIT, 3);
		offer_tick(DRV_UP | JAM_HIT);
		repeat_tick(JAM_HIT | BOTTOM_HIT, 2);
		repeat_tick(DRV_DOWN | JAM_HIT | BOTTOM_HIT, 3);
		offer_tick(NO_PRESS);
		// Released and jammed on the same tick: the jam wins.
		repeat_tick(DRV_UP, 3);
		offer_tick(JAM_HIT);
		repeat_tick(NO_PRESS, 2);
		// A short press straight after the manual run is swallowed; limit and jam then arrive while idle.
		offer_tick(DRV_UP);
		repeat_tick(NO_PRESS, 2);
		offer_tick(TOP_HIT | JAM_HIT);
		repeat_tick(NO_PRESS, 2);
		// Automatic down to the bottom limit.
		offer_tick(DRV_DOWN);
		repeat_tick(JAM_HIT, 2);
		offer_tick(BOTTOM_HIT);
	endtask

	// Steps at their extremes force the duty wrap on every moving tick, and a
	// zero step leaves the duty where it is.
	task automatic test_duty_wrap();
		write_config(make_config(16'd1, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF));
		repeat_tick(DRV_UP, 4);
		offer_tick(NO_PRESS);
		repeat_tick(DRV_DOWN, 4);
		offer_tick(NO_PRESS);
		write_config(make_config(16'd1, 16'd1, 16'd0, 16'hFFFF, 16'd1));
		repeat_tick(DRV_DOWN, 4);
		offer_tick(NO_PRESS);
		repeat_tick(DRV_UP, 4);
		offer_tick(NO_PRESS);
	endtask

	// Zero hold decides on the first judging tick; zero reverse gives one reversal tick.
	task automatic test_zero_counts();
		write_config(make_config(16'd0, 16'd0, 16'd7, 16'd300, 16'd900));
		repeat_tick(DRV_UP, 3);
		offer_tick(DRV_UP | JAM_HIT);
		repeat_tick(NO_PRESS, 2);
	endtask

	// Long counts: a judgement and a reversal that each run over many ticks.
	task automatic test_long_counts();
		write_config(make_config(16'd150, 16'd150, 16'd3, 16'd5, 16'd4000));
		repeat_tick(DRV_UP, 152);
		offer_tick(DRV_UP | JAM_HIT);
		repeat_tick(NO_PRESS, 152);
	endtask

	// The receiver holds off for a long stretch while items keep coming, so the
	// block fills and drops in_ready; then the sender waits for every result.
	task automatic test_backpressure();
		write_config(make_config(16'd2, 16'd3, 16'd40, 16'd90, 16'd700));
		holdoff_requests++;
		send_tick(DRV_UP);
		repeat (40) send_tick(tick_t'($urandom_range(0, 255)));
		drain_results();
	endtask

	function automatic logic [15:0] random_step();
		case ($urandom_range(0, 4))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(1, 200));
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		c.hold_ticks    = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(11, 40))
			: 16'($urandom_range(0, 10));
		c.reverse_ticks = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(11, 40))
			: 16'($urandom_range(0, 10));
		c.up_step       = random_step();
		c.down_step     = random_step();
		case ($urandom_range(0, 5))
			0:       c.pwm_period = 16'd1;
			1:       c.pwm_period = 16'hFFFF;
			2:       c.pwm_period = 16'd0;
			3:       c.pwm_period = 16'($urandom_range(1, 500));
			default: c.pwm_period = 16'($urandom_range(1, 16'hFFFF));
		endcase
		return c;
	endfunction

	// One window operation: a press held either past the judgement (manual) or
	// not (automatic), a limit switch closing at some point afterwards, perhaps
	// a jam, and a sprinkling of stray inputs. Now and then pure noise instead.
	task automatic run_scenario();
		int         span;
		int         press_len;
		int         limit_at;
		int         jam_at;
		int         src;
		tick_t      t;
		logic [3:0] buttons;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 12)) begin
				offer_tick(tick_t'($urandom_range(0, 255)));
				random_items++;
			end
			return;
		end
		src = $urandom_range(0, 3);
		if (win_cfg.hold_ticks != 0 && $urandom_range(0, 1))
			press_len = $urandom_range(1, win_cfg.hold_ticks);
		else
			press_len = win_cfg.hold_ticks + $urandom_range(1, 30);
		span = press_len + win_cfg.hold_ticks + $urandom_range(1, 40);
		limit_at = $urandom_range(win_cfg.hold_ticks + 1, span);
		jam_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span) : -1;
		for (int i = 0; i < span; i++) begin
			buttons = '0;
			if (i < press_len)
				buttons[src] = 1'b1;
			if ($urandom_range(0, 15) == 0)
				buttons[$urandom_range(0, 3)] = 1'b1;
			t = '0;
			t.driver_up    = buttons[0];
			t.driver_down  = buttons[1];
			t.pass_up      = buttons[2];
			t.pass_down    = buttons[3];
			t.lock_off     = (src >= 2) ? ($urandom_range(0, 7) != 0)
				: 1'($urandom_range(0, 1));
			t.top_limit    = (i >= limit_at) || ($urandom_range(0, 31) == 0);
			t.bottom_limit = (i >= limit_at) || ($urandom_range(0, 31) == 0);
			t.jam          = (i == jam_at) || ($urandom_range(0, 63) == 0);
			offer_tick(t);
			random_items++;
		end
	endtask

	// Random operations in phases, each phase under freshly written registers.
	task automatic test_random_traffic();
		int phase_end;
		while (random_items < RANDOM_ITEMS) begin
			write_config(random_config());
			phase_end = random_items + PHASE_ITEMS;
			while (random_items < phase_end)
				run_scenario();
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		reset_window_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_button_priority();
		test_lock_during_press();
		test_short_press_after_manual();
		test_limits_and_jam();
		test_duty_wrap();
		test_zero_counts();
		test_backpressure();
		test_random_traffic();
		test_long_counts();
		drain_results();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/pwc_pkg.sv
rtl/pwc_step.sv
rtl/power_window_controller_unit.sv
rtl/pwc_checker.sv
dv/power_window_controller_unit_tb.sv
